// File: rtl/rau_pkg.sv
// Shared types, constants and helper functions for the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [2*WIDTH-1:0] MUL_LIM = {(WIDTH)'(0), 1'b1, (WIDTH-1)'(0)};
    localparam logic [WIDTH-1:0]   DIV_LIM = {1'b1, (WIDTH-1)'(0)};

    localparam logic [2:0] MD_REDUCE  = 3'd0;
    localparam logic [2:0] MD_ADD     = 3'd1;
    localparam logic [2:0] MD_SUB     = 3'd2;
    localparam logic [2:0] MD_MUL     = 3'd3;
    localparam logic [2:0] MD_DIV     = 3'd4;
    localparam logic [2:0] MD_LESS    = 3'd5;
    localparam logic [2:0] MD_GREATER = 3'd6;
    localparam logic [2:0] MD_UNKNOWN = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_SEQ, S_MULW, S_DIVW, S_GCDW, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_GCD, OP_DIV, OP_MUL, OP_ADD, OP_CMP, OP_END
    } op_t;

    typedef enum logic [2:0] {
        SRC_N1, SRC_D1, SRC_N2, SRC_D2, SRC_G, SRC_L, SRC_T, SRC_T1
    } src_t;

    typedef enum logic [3:0] {
        DST_T, DST_L, DST_T1, DST_NUM, DST_DEN, DST_LP, DST_RP, DST_NONE
    } dst_t;

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] dvd;
        logic [WIDTH-1:0] dvs;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic             ov;
        logic [WIDTH-1:0] val;
    } wrap_t;

    // Bring a 32-bit input operand to WIDTH bits, flag any change of value
    function automatic wrap_t take_in(logic [31:0] x);
        logic signed [63:0] v;
        logic [WIDTH-1:0]   w;
        logic signed [63:0] e;
        wrap_t              r;
        v = 64'(signed'(x));
        w = v[WIDTH-1:0];
        e = 64'(signed'(w));
        r.val = w;
        r.ov  = (e != v);
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] mag(logic [WIDTH-1:0] x);
        return x[WIDTH-1] ? (WIDTH)'(-x) : x;
    endfunction

    function automatic logic [31:0] out32(logic [WIDTH-1:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[31:0];
    endfunction

endpackage

// File: rtl/rau_divu.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rau_divu import rau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   sh;
    logic [WIDTH+1:0] diff;

    assign sh   = {rem_reg, quo_reg[WIDTH-1]};
    assign diff = {1'b0, sh} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_W'(WIDTH-1));
            if (req.start) begin
                rem_reg  <= '0;
                quo_reg  <= req.dvd;
                dvs_reg  <= req.dvs;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[WIDTH+1]) begin
                    rem_reg <= diff[WIDTH-1:0];
                    quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
                end else begin
                    rem_reg <= sh[WIDTH-1:0];
                    quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH-1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, multiplier, divider and register set.
`timescale 1ns / 1ps

// Exact arithmetic on two signed fractions. The s_ channel carries one beat per
// operation (mode, a_num/a_den, b_num/b_den); the m_ channel returns one beat
// with the result fraction, the comparison outcome and the zero-divisor and
// overflow flags. Both channels use valid/ready.
// One operation is worked at a time: s_ready is high only while the unit is
// idle. Work runs on one shared multiplier (the product is registered in SEQ
// and written back in MULW) and one shared bit-serial divider, which also
// serves every remainder step of the Euclid gcd. A zero denominator, a zero
// b_num in divide or an unknown mode skips the sequencer and goes from DISP
// straight to OUT.
// The result beat is held on the m_ ports until m_ready; no new beat is taken
// before it leaves. Reset (aresetn low, synchronous) returns the unit to idle
// and drops any beat in flight.
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_a_num,
    input  logic [31:0] s_a_den,
    input  logic [31:0] s_b_num,
    input  logic [31:0] s_b_den,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_res_num,
    output logic [31:0] m_res_den,
    output logic        m_cmp_true,
    output logic        m_zero_divisor,
    output logic        m_overflowed
);

    state_t state_reg, state_next;

    logic [2:0]         mode_reg;
    logic [3:0]         pc_reg;
    logic [WIDTH-1:0]   n1_reg, d1_reg, n2_reg, d2_reg;
    logic [WIDTH-1:0]   g_reg, prev_reg, l_reg, t_reg, t1_reg;
    logic [WIDTH-1:0]   num_reg, den_reg;
    logic signed [2*WIDTH:0] lp_reg, rp_reg;
    logic [2*WIDTH-1:0] prod_reg;
    logic               mneg_reg;
    logic               xneg_reg;
    logic               qneg_reg;
    logic               ov_reg, zd_reg, cmp_reg;

    op_t  op;
    src_t sa, sb;
    dst_t dst;

    logic [WIDTH-1:0] va, vb;
    wrap_t w_an, w_ad, w_bn, w_bd;
    logic  zd_now;

    div_req_t dreq;
    div_rsp_t drsp;

    logic             wb_en;
    logic [WIDTH-1:0] wb_val;
    logic             wb_ov;

    logic [WIDTH-1:0] mul_lo;
    logic             mul_ov;
    logic signed [2*WIDTH:0] mul_full;
    logic [WIDTH-1:0] q_val;
    logic             q_ov;
    logic [WIDTH-1:0] r_val;
    logic [WIDTH:0]   sum;
    logic             add_ov;
    logic             flip;
    logic             cmp_val;

    rau_divu u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign w_an = take_in(s_a_num);
    assign w_ad = take_in(s_a_den);
    assign w_bn = take_in(s_b_num);
    assign w_bd = take_in(s_b_den);

    assign zd_now = (d1_reg == '0) ||
                    ((mode_reg != MD_REDUCE) &&
                     ((d2_reg == '0) || ((mode_reg == MD_DIV) && (n2_reg == '0))));

    // Micro-program: one step per pc value for each mode
    always_comb begin
        op  = OP_END;
        sa  = SRC_N1;
        sb  = SRC_D1;
        dst = DST_NONE;
        unique case (mode_reg)
            MD_REDUCE: begin
                case (pc_reg)
                    4'd0: begin op = OP_GCD; sa = SRC_N1; sb = SRC_D1; end
                    4'd1: begin op = OP_DIV; sa = SRC_N1; sb = SRC_G; dst = DST_NUM; end
                    4'd2: begin op = OP_DIV; sa = SRC_D1; sb = SRC_G; dst = DST_DEN; end
                    default: op = OP_END;
                endcase
            end
            MD_ADD, MD_SUB: begin
                case (pc_reg)
                    4'd0: begin op = OP_MUL; sa = SRC_D1; sb = SRC_D2; dst = DST_T; end
                    4'd1: begin op = OP_GCD; sa = SRC_D1; sb = SRC_D2; end
                    4'd2: begin op = OP_DIV; sa = SRC_T;  sb = SRC_G;  dst = DST_L; end
                    4'd3: begin op = OP_MUL; sa = SRC_N1; sb = SRC_L;  dst = DST_T; end
                    4'd4: begin op = OP_DIV; sa = SRC_T;  sb = SRC_D1; dst = DST_T1; end
                    4'd5: begin op = OP_MUL; sa = SRC_N2; sb = SRC_L;  dst = DST_T; end
                    4'd6: begin op = OP_DIV; sa = SRC_T;  sb = SRC_D2; dst = DST_T; end
                    4'd7: begin op = OP_ADD; sa = SRC_T1; sb = SRC_T; end
                    default: op = OP_END;
                endcase
            end
            MD_MUL: begin
                case (pc_reg)
                    4'd0: begin op = OP_MUL; sa = SRC_N1; sb = SRC_N2; dst = DST_NUM; end
                    4'd1: begin op = OP_MUL; sa = SRC_D1; sb = SRC_D2; dst = DST_DEN; end
                    default: op = OP_END;
                endcase
            end
            MD_DIV: begin
                case (pc_reg)
                    4'd0: begin op = OP_MUL; sa = SRC_N1; sb = SRC_D2; dst = DST_NUM; end
                    4'd1: begin op = OP_MUL; sa = SRC_D1; sb = SRC_N2; dst = DST_DEN; end
                    default: op = OP_END;
                endcase
            end
            MD_LESS, MD_GREATER: begin
                case (pc_reg)
                    4'd0: begin op = OP_MUL; sa = SRC_N1; sb = SRC_D2; dst = DST_LP; end
                    4'd1: begin op = OP_MUL; sa = SRC_N2; sb = SRC_D1; dst = DST_RP; end
                    4'd2: op = OP_CMP;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
    end

    function automatic logic [WIDTH-1:0] pick(src_t s, logic [WIDTH-1:0] n1,
            logic [WIDTH-1:0] d1, logic [WIDTH-1:0] n2, logic [WIDTH-1:0] d2,
            logic [WIDTH-1:0] g, logic [WIDTH-1:0] l, logic [WIDTH-1:0] t,
            logic [WIDTH-1:0] t1);
        logic [WIDTH-1:0] v;
        unique case (s)
            SRC_N1:  v = n1;
            SRC_D1:  v = d1;
            SRC_N2:  v = n2;
            SRC_D2:  v = d2;
            SRC_G:   v = g;
            SRC_L:   v = l;
            SRC_T:   v = t;
            default: v = t1;
        endcase
        return v;
    endfunction

    assign va = pick(sa, n1_reg, d1_reg, n2_reg, d2_reg, g_reg, l_reg, t_reg, t1_reg);
    assign vb = pick(sb, n1_reg, d1_reg, n2_reg, d2_reg, g_reg, l_reg, t_reg, t1_reg);

    // Wrap the registered product to WIDTH bits, flag overflow and form the full signed product
    always_comb begin
        mul_lo   = mneg_reg ? (WIDTH)'(-prod_reg[WIDTH-1:0]) : prod_reg[WIDTH-1:0];
        mul_ov   = mneg_reg ? (prod_reg > MUL_LIM) : (prod_reg >= MUL_LIM);
        mul_full = mneg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    end

    // Signed quotient and remainder from the divider magnitudes
    always_comb begin
        if (qneg_reg && (drsp.quo != '0)) begin
            q_ov  = drsp.quo > DIV_LIM;
            q_val = (WIDTH)'(-drsp.quo);
        end else begin
            q_ov  = drsp.quo >= DIV_LIM;
            q_val = drsp.quo;
        end
        r_val = xneg_reg ? (WIDTH)'(-drsp.rem) : drsp.rem;
    end

    always_comb begin
        if (mode_reg == MD_SUB) begin
            sum    = {1'b0, va} - {1'b0, vb};
            add_ov = (va[WIDTH-1] != vb[WIDTH-1]) && (sum[WIDTH-1] != va[WIDTH-1]);
        end else begin
            sum    = {1'b0, va} + {1'b0, vb};
            add_ov = (va[WIDTH-1] == vb[WIDTH-1]) && (sum[WIDTH-1] != va[WIDTH-1]);
        end
        flip = d1_reg[WIDTH-1] != d2_reg[WIDTH-1];
        if (mode_reg == MD_LESS) begin
            cmp_val = flip ? (lp_reg > rp_reg) : (lp_reg < rp_reg);
        end else begin
            cmp_val = flip ? (lp_reg < rp_reg) : (lp_reg > rp_reg);
        end
    end

    // Divider requests: operation start in SEQ, next Euclid step in GCDW
    always_comb begin
        dreq.start = 1'b0;
        dreq.dvd   = mag(va);
        dreq.dvs   = mag(vb);
        if (state_reg == S_SEQ) begin
            dreq.start = (op == OP_GCD) || ((op == OP_DIV) && (vb != '0));
        end else if (state_reg == S_GCDW) begin
            dreq.dvd   = mag(prev_reg);
            dreq.dvs   = mag(r_val);
            dreq.start = drsp.done && (r_val != '0);
        end
    end

    // Write-back of products and quotients, and of zero for a divide by zero in SEQ
    always_comb begin
        wb_en  = 1'b0;
        wb_val = '0;
        wb_ov  = 1'b0;
        if (state_reg == S_MULW) begin
            wb_en  = 1'b1;
            wb_val = mul_lo;
            wb_ov  = mul_ov && (dst != DST_LP) && (dst != DST_RP);
        end else if ((state_reg == S_DIVW) && drsp.done) begin
            wb_en  = 1'b1;
            wb_val = q_val;
            wb_ov  = q_ov;
        end else if ((state_reg == S_SEQ) && (op == OP_DIV) && (vb == '0)) begin
            wb_en  = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_DISP;
            S_DISP: begin
                if ((mode_reg == MD_UNKNOWN) || zd_now) state_next = S_OUT;
                else state_next = S_SEQ;
            end
            S_SEQ: begin
                unique case (op)
                    OP_MUL: state_next = S_MULW;
                    OP_DIV: state_next = (vb == '0) ? S_SEQ : S_DIVW;
                    OP_GCD: state_next = S_GCDW;
                    OP_END: state_next = S_OUT;
                    default: state_next = S_SEQ;
                endcase
            end
            S_MULW: state_next = S_SEQ;
            S_DIVW: if (drsp.done) state_next = S_SEQ;
            S_GCDW: if (drsp.done && (r_val == '0)) state_next = S_SEQ;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                mode_reg <= s_mode;
                n1_reg   <= w_an.val;
                d1_reg   <= w_ad.val;
                if (s_mode == MD_REDUCE) begin
                    n2_reg <= '0;
                    d2_reg <= '0;
                    ov_reg <= w_an.ov | w_ad.ov;
                end else begin
                    n2_reg <= w_bn.val;
                    d2_reg <= w_bd.val;
                    ov_reg <= w_an.ov | w_ad.ov | w_bn.ov | w_bd.ov;
                end
            end
            S_DISP: begin
                pc_reg  <= '0;
                num_reg <= '0;
                den_reg <= '0;
                cmp_reg <= 1'b0;
                zd_reg  <= (mode_reg != MD_UNKNOWN) && zd_now;
                if ((mode_reg == MD_UNKNOWN) || zd_now) begin
                    ov_reg <= 1'b0;
                end
            end
            S_SEQ: begin
                mneg_reg <= va[WIDTH-1] != vb[WIDTH-1];
                qneg_reg <= va[WIDTH-1] != vb[WIDTH-1];
                xneg_reg <= va[WIDTH-1];
                prod_reg <= {WIDTH'(0), mag(va)} * {WIDTH'(0), mag(vb)};
                case (op)
                    OP_GCD: begin
                        g_reg    <= vb;
                        prev_reg <= vb;
                    end
                    OP_ADD: begin
                        num_reg <= sum[WIDTH-1:0];
                        den_reg <= l_reg;
                        ov_reg  <= ov_reg | add_ov;
                        pc_reg  <= pc_reg + 1'b1;
                    end
                    OP_CMP: begin
                        cmp_reg <= cmp_val;
                        pc_reg  <= pc_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            S_GCDW: begin
                if (drsp.done) begin
                    if (r_val == '0) begin
                        pc_reg <= pc_reg + 1'b1;
                    end else begin
                        g_reg    <= r_val;
                        prev_reg <= r_val;
                        xneg_reg <= prev_reg[WIDTH-1];
                    end
                end
            end
            default: ;
        endcase

        if (wb_en) begin
            pc_reg <= pc_reg + 1'b1;
            ov_reg <= ov_reg | wb_ov;
            case (dst)
                DST_T:   t_reg   <= wb_val;
                DST_L:   l_reg   <= wb_val;
                DST_T1:  t1_reg  <= wb_val;
                DST_NUM: num_reg <= wb_val;
                DST_DEN: den_reg <= wb_val;
                DST_LP:  lp_reg  <= mul_full;
                DST_RP:  rp_reg  <= mul_full;
                default: ;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_OUT);
    assign m_res_num      = out32(num_reg);
    assign m_res_den      = out32(den_reg);
    assign m_cmp_true     = cmp_reg;
    assign m_zero_divisor = zd_reg;
    assign m_overflowed   = ov_reg;

endmodule

// File: dv/rational_arithmetic_unit_tb.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int  N_RANDOM   = 880;
    localparam longint LIMIT   = 6000000;
    localparam int  HOLD_LEN   = 500;
    localparam int  DRAIN_LEN  = 2000;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
        logic        cmp;
        logic        zd;
        logic        ov;
    } frac_res_t;

    typedef struct {
        logic [2:0]  md;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        bit          typed;
        frac_res_t   want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_mode;
    logic [31:0] s_a_num;
    logic [31:0] s_a_den;
    logic [31:0] s_b_num;
    logic [31:0] s_b_den;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_res_num;
    logic [31:0] m_res_den;
    logic        m_cmp_true;
    logic        m_zero_divisor;
    logic        m_overflowed;

    frac_res_t   pending_q[$];
    stim_row_t   dir_rows[$];
    int          n_sent;
    int          n_checked;
    int          n_bad;
    int          mode_hits[8];
    longint      cycles;
    bit          quiet;
    bit          hold_rx;

    rational_arithmetic_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_a_num       (s_a_num),
        .s_a_den       (s_a_den),
        .s_b_num       (s_b_num),
        .s_b_den       (s_b_den),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res_num     (m_res_num),
        .m_res_den     (m_res_den),
        .m_cmp_true    (m_cmp_true),
        .m_zero_divisor(m_zero_divisor),
        .m_overflowed  (m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---- predictor: WIDTH-bit two's complement held in 64-bit words ----
    function automatic logic [63:0] wrap_w(logic [63:0] x);
        logic [63:0] m;
        if (WIDTH >= 64) begin
            return x;
        end
        m = (64'd1 << WIDTH) - 64'd1;
        x = x & m;
        if (x[WIDTH-1]) begin
            x = x | ~m;
        end
        return x;
    endfunction

    function automatic logic [63:0] abs_w(logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] clamp_flag(bit neg, logic [63:0] mg, inout bit ov);
        logic [63:0] lim;
        lim = 64'd1 << (WIDTH - 1);
        if (neg ? (mg > lim) : (mg >= lim)) begin
            ov = 1'b1;
        end
        return wrap_w(neg ? 64'd0 - mg : mg);
    endfunction

    function automatic logic [63:0] sum_w(logic [63:0] x, logic [63:0] y, bit sub,
                                          inout bit ov);
        logic [63:0] s;
        s = sub ? x - y : x + y;
        if (((x[63] == y[63]) != sub) && s[63] != x[63]) begin
            ov = 1'b1;
        end
        if (wrap_w(s) != s) begin
            ov = 1'b1;
        end
        return wrap_w(s);
    endfunction

    function automatic logic [63:0] prod_w(logic [63:0] x, logic [63:0] y, inout bit ov);
        logic [127:0] p;
        bit           neg;
        p   = {64'd0, abs_w(x)} * {64'd0, abs_w(y)};
        neg = (x[63] != y[63]);
        if (p[127:64] != 64'd0) begin
            ov = 1'b1;
            return wrap_w(neg ? 64'd0 - p[63:0] : p[63:0]);
        end
        return clamp_flag(neg && p[63:0] != 64'd0, p[63:0], ov);
    endfunction

    function automatic logic [63:0] quot_w(logic [63:0] x, logic [63:0] y, inout bit ov);
        logic [63:0] q;
        if (y == 64'd0) begin
            return 64'd0;
        end
        q = abs_w(x) / abs_w(y);
        return clamp_flag((x[63] != y[63]) && q != 64'd0, q, ov);
    endfunction

    function automatic logic [63:0] rem_w(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        if (y == 64'd0) begin
            return 64'd0;
        end
        r = abs_w(x) % abs_w(y);
        return wrap_w(x[63] ? 64'd0 - r : r);
    endfunction

    // Euclid on truncating remainders; b itself when b divides a
    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] r, prev, g;
        r    = rem_w(a, b);
        prev = b;
        g    = b;
        while (r != 64'd0) begin
            g    = r;
            r    = rem_w(prev, r);
            prev = g;
        end
        return g;
    endfunction

    function automatic logic [63:0] load_w(logic [31:0] raw, inout bit ov);
        logic [63:0] v;
        v = {{32{raw[31]}}, raw};
        if (wrap_w(v) != v) begin
            ov = 1'b1;
        end
        return wrap_w(v);
    endfunction

    function automatic frac_res_t rational_result(logic [2:0] md, logic [31:0] an,
                                                  logic [31:0] ad, logic [31:0] bn,
                                                  logic [31:0] bd);
        bit          ov, zd, cmp, flip;
        logic [63:0] n1, d1, n2, d2, num, den, l, t1, t2;
        longint      lhs, rhs;
        frac_res_t   r;
        ov  = 1'b0;
        zd  = 1'b0;
        cmp = 1'b0;
        num = '0;
        den = '0;
        n2  = '0;
        d2  = '0;
        n1  = load_w(an, ov);
        d1  = load_w(ad, ov);
        if (md != MD_REDUCE) begin
            n2 = load_w(bn, ov);
            d2 = load_w(bd, ov);
            if (d2 == 64'd0 || (md == MD_DIV && n2 == 64'd0)) begin
                zd = 1'b1;
            end
        end
        if (d1 == 64'd0) begin
            zd = 1'b1;
        end
        if (md == MD_UNKNOWN) begin
            ov = 1'b0;
            zd = 1'b0;
        end else if (!zd) begin
            case (md)
                MD_REDUCE: begin
                    l   = euclid_gcd(n1, d1);
                    num = quot_w(n1, l, ov);
                    den = quot_w(d1, l, ov);
                end
                MD_ADD, MD_SUB: begin
                    l   = prod_w(d1, d2, ov);
                    l   = quot_w(l, euclid_gcd(d1, d2), ov);
                    t1  = quot_w(prod_w(n1, l, ov), d1, ov);
                    t2  = quot_w(prod_w(n2, l, ov), d2, ov);
                    num = sum_w(t1, t2, md == MD_SUB, ov);
                    den = l;
                end
                MD_MUL: begin
                    num = prod_w(n1, n2, ov);
                    den = prod_w(d1, d2, ov);
                end
                MD_DIV: begin
                    num = prod_w(n1, d2, ov);
                    den = prod_w(d1, n2, ov);
                end
                default: begin
                    lhs  = longint'(n1) * longint'(d2);
                    rhs  = longint'(n2) * longint'(d1);
                    flip = (d1[63] != d2[63]);
                    if (md == MD_LESS) begin
                        cmp = flip ? (lhs > rhs) : (lhs < rhs);
                    end else begin
                        cmp = flip ? (lhs < rhs) : (lhs > rhs);
                    end
                end
            endcase
        end
        if (zd) begin
            ov  = 1'b0;
            num = '0;
            den = '0;
            cmp = 1'b0;
        end
        r.num = num[31:0];
        r.den = den[31:0];
        r.cmp = cmp;
        r.zd  = zd;
        r.ov  = ov;
        return r;
    endfunction

    // ---- random fields: mostly small, some extremes, some full range ----
    function automatic logic [31:0] pick_field();
        case ($urandom_range(9))
            0:       return 32'd0;
            1, 2, 3: return 32'($urandom_range(40)) - 32'd20;
            4, 5:    return 32'($urandom_range(4000)) - 32'd2000;
            6: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_ffff;
                    default: return 32'd1;
                endcase
            end
            7:       return 32'($urandom_range(200000)) - 32'd100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t pred_row(logic [2:0] md, logic [31:0] an, logic [31:0] ad,
                                           logic [31:0] bn, logic [31:0] bd);
        stim_row_t r;
        r.md    = md;
        r.an    = an;
        r.ad    = ad;
        r.bn    = bn;
        r.bd    = bd;
        r.typed = 1'b0;
        r.want  = '{default: '0};
        return r;
    endfunction

    function automatic stim_row_t zd_row(logic [2:0] md, logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [31:0] bd, bit zd);
        stim_row_t r;
        r        = pred_row(md, an, ad, bn, bd);
        r.typed  = 1'b1;
        r.want.zd = zd;
        return r;
    endfunction

    initial begin
        // error codes and unknown mode: all-zero results, typed in
        dir_rows.push_back(zd_row(MD_REDUCE,  32'd7,  32'd0, 32'd1, 32'd1, 1'b1));
        dir_rows.push_back(zd_row(MD_ADD,     32'd1,  32'd2, 32'd3, 32'd0, 1'b1));
        dir_rows.push_back(zd_row(MD_SUB,     32'd1,  32'd0, 32'd3, 32'd4, 1'b1));
        dir_rows.push_back(zd_row(MD_MUL,     32'h8000_0000, 32'd0, 32'hffff_ffff, 32'd0, 1'b1));
        dir_rows.push_back(zd_row(MD_DIV,     32'd5,  32'd6, 32'd0, 32'd9, 1'b1));
        dir_rows.push_back(zd_row(MD_LESS,    32'd1,  32'd0, 32'd2, 32'd3, 1'b1));
        dir_rows.push_back(zd_row(MD_GREATER, 32'd1,  32'd3, 32'd2, 32'd0, 1'b1));
        dir_rows.push_back(zd_row(MD_UNKNOWN, 32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'd0, 1'b0));
        dir_rows.push_back(zd_row(MD_UNKNOWN, 32'h8000_0000, 32'h7fff_ffff, 32'd3, 32'd4, 1'b0));
        // arithmetic rows, against the predictor
        dir_rows.push_back(pred_row(MD_REDUCE,  32'd6,   32'd4,   32'd0, 32'd0));
        dir_rows.push_back(pred_row(MD_REDUCE,  32'd5,   32'd10,  32'd9, 32'd9));
        dir_rows.push_back(pred_row(MD_REDUCE,  -32'sd8, 32'd4,   32'd0, 32'd0));
        dir_rows.push_back(pred_row(MD_REDUCE,  32'd0,   -32'sd7, 32'd0, 32'd0));
        dir_rows.push_back(pred_row(MD_REDUCE,  32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0));
        dir_rows.push_back(pred_row(MD_REDUCE,  32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0));
        dir_rows.push_back(pred_row(MD_ADD,     32'd1,   32'd2,   32'd1, 32'd3));
        dir_rows.push_back(pred_row(MD_SUB,     32'd1,   32'd4,   -32'sd5, 32'd6));
        dir_rows.push_back(pred_row(MD_ADD,     32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1));
        dir_rows.push_back(pred_row(MD_SUB,     32'h8000_0000, 32'd1, 32'd1, 32'd1));
        dir_rows.push_back(pred_row(MD_MUL,     32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd3));
        dir_rows.push_back(pred_row(MD_MUL,     32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1));
        dir_rows.push_back(pred_row(MD_DIV,     -32'sd3, 32'd4,   32'd5, -32'sd7));
        dir_rows.push_back(pred_row(MD_LESS,    32'd1,   -32'sd2, 32'd1, 32'd3));
        dir_rows.push_back(pred_row(MD_GREATER, 32'd2,   32'd4,   32'd1, 32'd2));
        dir_rows.push_back(pred_row(MD_LESS,    32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 16);
    endfunction

    // ---- sender ----
    task automatic offer_beat(stim_row_t row);
        frac_res_t exp_res;
        if (idle_roll()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_roll()) begin
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_mode  <= row.md;
        s_a_num <= row.an;
        s_a_den <= row.ad;
        s_b_num <= row.bn;
        s_b_den <= row.bd;
        exp_res = row.typed ? row.want
                            : rational_result(row.md, row.an, row.ad, row.bn, row.bd);
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_q.push_back(exp_res);
        mode_hits[row.md]++;
        n_sent++;
    endtask

    initial begin
        stim_row_t row;
        s_valid = 1'b0;
        s_mode  = '0;
        s_a_num = '0;
        s_a_den = '0;
        s_b_num = '0;
        s_b_den = '0;
        aresetn = 1'b0;
        quiet   = 1'b0;
        n_sent  = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            offer_beat(dir_rows[i]);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= 400 && i < 500);
            if (i == 650) begin
                // pause until the unit has drained
                s_valid <= 1'b0;
                while (pending_q.size() != 0) begin
                    @(posedge aclk);
                end
            end
            row = pred_row(3'($urandom_range(7)), pick_field(), pick_field(),
                           pick_field(), pick_field());
            offer_beat(row);
        end
        s_valid <= 1'b0;
        quiet = 1'b0;
        while (pending_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_LEN) @(posedge aclk);
        $display("Checked %0d results from %0d beats; per mode: %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_checked, n_sent, mode_hits[0], mode_hits[1], mode_hits[2],
                 mode_hits[3], mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
        $display("Covered zero divisors, overflow wrap, extremes and receiver back-pressure.");
        if (n_bad == 0 && pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // long receiver hold-off once the random part is under way
    initial begin
        hold_rx = 1'b0;
        wait (n_sent >= 200);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        hold_rx = 1'b0;
    end

    // ---- receiver and checker ----
    initial begin
        frac_res_t want;
        m_ready   = 1'b0;
        n_checked = 0;
        n_bad     = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("Unexpected result beat: num %h den %h", m_res_num, m_res_den);
                    end
                end else begin
                    want = pending_q.pop_front();
                    n_checked++;
                    if (m_res_num !== want.num || m_res_den !== want.den ||
                        m_cmp_true !== want.cmp || m_zero_divisor !== want.zd ||
                        m_overflowed !== want.ov) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("Mismatch at result %0d: exp num %h den %h cmp %b zd %b ov %b",
                                     n_checked, want.num, want.den, want.cmp, want.zd, want.ov);
                            $display("                      got num %h den %h cmp %b zd %b ov %b",
                                     m_res_num, m_res_den, m_cmp_true, m_zero_divisor,
                                     m_overflowed);
                        end
                    end
                end
            end
            m_ready <= !hold_rx && !idle_roll();
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
